### design/ttcc_pkg.sv
// Shared types, codes and constants of the text terminal cursor controller.
package ttcc_pkg;

    localparam int MAX_COLUMNS_DEF = 128;
    localparam int MAX_ROWS_DEF    = 48;

    localparam int CFG_ADDR_W  = 4;
    localparam int QUEUE_DEPTH = 2;
    localparam int NL_CNT_W    = 3;

    localparam logic [1:0] REG_ENABLE  = 2'd0;
    localparam logic [1:0] REG_COLUMNS = 2'd1;
    localparam logic [1:0] REG_ROWS    = 2'd2;

    localparam logic [7:0] COLUMNS_RESET = 8'd80;
    localparam logic [5:0] ROWS_RESET    = 6'd25;

    localparam logic [7:0] CH_BELL  = 8'h07;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_BLANK = 8'h20;

    localparam int              TAB_STEP = 8;
    localparam logic [NL_CNT_W-1:0] VT_LINES = 3'd6;

    typedef enum logic [1:0] {
        KIND_WRITE  = 2'd0,
        KIND_SCROLL = 2'd1,
        KIND_DONE   = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_CR,
        OP_BS,
        OP_NL,
        OP_VT,
        OP_TAB,
        OP_PRINT
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] glyph;
    } cmd_t;

endpackage

### design/ttcc_front.sv
// Front end: configuration registers, grid clamping and character classification.
module ttcc_front #(
    parameter int MAX_COLUMNS = ttcc_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_ROWS    = ttcc_pkg::MAX_ROWS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [ttcc_pkg::CFG_ADDR_W-1:0]      paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [7:0]                           s_tdata,
    input  logic                                 q_ready,
    output logic                                 q_push,
    output ttcc_pkg::cmd_t                       q_cmd,
    output logic [$clog2(MAX_COLUMNS+1)-1:0]     width_eff,
    output logic [$clog2(MAX_ROWS+1)-1:0]        height_eff
);

    localparam int WID_W = $clog2(MAX_COLUMNS + 1);
    localparam int HGT_W = $clog2(MAX_ROWS + 1);

    logic       enable_reg;
    logic [7:0] columns_reg;
    logic [5:0] rows_reg;
    logic       wr_en;
    ttcc_pkg::op_t op;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg  <= 1'b0;
            columns_reg <= ttcc_pkg::COLUMNS_RESET;
            rows_reg    <= ttcc_pkg::ROWS_RESET;
        end else if (wr_en) begin
            unique case (paddr[3:2])
                ttcc_pkg::REG_ENABLE:  enable_reg  <= pwdata[0];
                ttcc_pkg::REG_COLUMNS: columns_reg <= pwdata[7:0];
                ttcc_pkg::REG_ROWS:    rows_reg    <= pwdata[5:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            ttcc_pkg::REG_ENABLE:  prdata = {31'd0, enable_reg};
            ttcc_pkg::REG_COLUMNS: prdata = {24'd0, columns_reg};
            ttcc_pkg::REG_ROWS:    prdata = {26'd0, rows_reg};
            default:               prdata = 32'd0;
        endcase
    end

    // a zero register acts as one; a value above the maximum is clamped to the maximum
    always_comb begin
        if (32'(columns_reg) > MAX_COLUMNS) begin
            width_eff = WID_W'(MAX_COLUMNS);
        end else if (columns_reg == 8'd0) begin
            width_eff = WID_W'(1);
        end else begin
            width_eff = WID_W'(columns_reg);
        end
        if (32'(rows_reg) > MAX_ROWS) begin
            height_eff = HGT_W'(MAX_ROWS);
        end else if (rows_reg == 6'd0) begin
            height_eff = HGT_W'(1);
        end else begin
            height_eff = HGT_W'(rows_reg);
        end
    end

    always_comb begin
        unique case (s_tdata) inside
            ttcc_pkg::CH_BELL, ttcc_pkg::CH_FF: op = ttcc_pkg::OP_NOP;
            ttcc_pkg::CH_BS:  op = ttcc_pkg::OP_BS;
            ttcc_pkg::CH_TAB: op = ttcc_pkg::OP_TAB;
            ttcc_pkg::CH_NL:  op = ttcc_pkg::OP_NL;
            ttcc_pkg::CH_VT:  op = ttcc_pkg::OP_VT;
            ttcc_pkg::CH_CR:  op = ttcc_pkg::OP_CR;
            default:          op = ttcc_pkg::OP_PRINT;
        endcase
        q_cmd.op    = enable_reg ? op : ttcc_pkg::OP_NOP;
        q_cmd.glyph = s_tdata;
    end

    assign s_tready = q_ready;
    assign q_push   = s_tvalid && q_ready;

endmodule

### design/ttcc_queue.sv
// Short command queue between the classifier and the cursor engine.
module ttcc_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  ttcc_pkg::cmd_t  push_cmd,
    output logic            in_ready,
    input  logic            pop,
    output logic            out_valid,
    output ttcc_pkg::cmd_t  out_cmd
);

    localparam int PTR_W = $clog2(ttcc_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(ttcc_pkg::QUEUE_DEPTH + 1);

    ttcc_pkg::cmd_t   entry_reg [ttcc_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_pop;

    assign in_ready  = count_reg != CNT_W'(ttcc_pkg::QUEUE_DEPTH);
    assign out_valid = count_reg != '0;
    assign out_cmd   = entry_reg[rd_ptr_reg];
    assign do_pop    = pop && out_valid;

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

### design/ttcc_back.sv
// Cursor engine: runs each command, keeps the cursor and drives the output register.
module ttcc_back #(
    parameter int MAX_COLUMNS = ttcc_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_ROWS    = ttcc_pkg::MAX_ROWS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              q_valid,
    input  ttcc_pkg::cmd_t                    q_cmd,
    output logic                              q_pop,
    input  logic [$clog2(MAX_COLUMNS+1)-1:0]  width_eff,
    input  logic [$clog2(MAX_ROWS+1)-1:0]     height_eff,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [23:0]                       m_tdata,
    output logic [1:0]                        m_tuser,
    output logic                              m_tlast
);

    localparam int COL_W = $clog2(MAX_COLUMNS);
    localparam int ROW_W = $clog2(MAX_ROWS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_BS,
        ST_TAB,
        ST_NL,
        ST_DONE
    } state_t;

    state_t                     state_reg, state_next;
    logic [COL_W-1:0]           col_reg, col_next;
    logic [ROW_W-1:0]           row_reg, row_next;
    logic [ttcc_pkg::NL_CNT_W-1:0] nl_left_reg, nl_left_next;
    logic [7:0]                 glyph_reg, glyph_next;

    logic                       m_valid_reg, m_valid_next;
    ttcc_pkg::kind_t            m_kind_reg, m_kind_next;
    logic [6:0]                 m_col_reg, m_col_next;
    logic [5:0]                 m_row_reg, m_row_next;
    logic [7:0]                 m_glyph_reg, m_glyph_next;
    logic                       m_last_reg, m_last_next;

    logic                       step;
    logic                       emit;
    ttcc_pkg::kind_t            emit_kind;
    logic [COL_W-1:0]           emit_col;
    logic [7:0]                 emit_glyph;
    logic [31:0]                col_wide;
    logic [31:0]                row_wide;
    logic [COL_W:0]             col_inc;
    logic [COL_W:0]             col_tab;
    logic [COL_W:0]             w_ext;
    logic [ROW_W:0]             row_inc;
    logic [ROW_W:0]             h_ext;
    logic [ROW_W-1:0]           row_top;

    assign step    = !m_valid_reg || m_tready;
    assign col_inc = {1'b0, col_reg} + (COL_W+1)'(1);
    assign col_tab = {1'b0, col_reg} + (COL_W+1)'(ttcc_pkg::TAB_STEP);
    assign w_ext   = (COL_W+1)'(width_eff);
    assign row_inc = {1'b0, row_reg} + (ROW_W+1)'(1);
    assign h_ext   = (ROW_W+1)'(height_eff);
    assign row_top = ROW_W'(height_eff - 1'b1);

    always_comb begin
        state_next   = state_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        nl_left_next = nl_left_reg;
        glyph_next   = glyph_reg;
        q_pop        = 1'b0;
        emit         = 1'b0;
        emit_kind    = ttcc_pkg::KIND_DONE;
        emit_col     = col_reg;
        emit_glyph   = 8'd0;

        unique case (state_reg)
            ST_IDLE: begin
                q_pop = q_valid;
            end
            ST_WRITE: begin
                if (step) begin
                    emit       = 1'b1;
                    emit_kind  = ttcc_pkg::KIND_WRITE;
                    emit_glyph = glyph_reg;
                    if (col_inc >= w_ext) begin
                        nl_left_next = ttcc_pkg::NL_CNT_W'(1);
                        state_next   = ST_NL;
                    end else begin
                        col_next   = col_inc[COL_W-1:0];
                        state_next = ST_DONE;
                    end
                end
            end
            ST_BS: begin
                if (step) begin
                    if (col_reg != '0) begin
                        col_next   = col_reg - 1'b1;
                        emit       = 1'b1;
                        emit_kind  = ttcc_pkg::KIND_WRITE;
                        emit_col   = col_reg - 1'b1;
                        emit_glyph = ttcc_pkg::CH_BLANK;
                    end
                    state_next = ST_DONE;
                end
            end
            ST_TAB: begin
                if (col_tab >= w_ext) begin
                    nl_left_next = ttcc_pkg::NL_CNT_W'(1);
                    state_next   = ST_NL;
                end else begin
                    col_next   = col_tab[COL_W-1:0];
                    state_next = ST_DONE;
                end
            end
            ST_NL: begin
                if (step) begin
                    col_next = '0;
                    if (row_inc >= h_ext) begin
                        emit      = 1'b1;
                        emit_kind = ttcc_pkg::KIND_SCROLL;
                        emit_col  = '0;
                        row_next  = row_top;
                    end else begin
                        row_next = row_inc[ROW_W-1:0];
                    end
                    nl_left_next = nl_left_reg - 1'b1;
                    if (nl_left_reg == ttcc_pkg::NL_CNT_W'(1)) begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                if (step) begin
                    emit       = 1'b1;
                    emit_kind  = ttcc_pkg::KIND_DONE;
                    q_pop      = q_valid;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        // next command is taken from idle, or in the cycle the previous done item is loaded into the output register
        if (q_pop) begin
            glyph_next = q_cmd.glyph;
            unique case (q_cmd.op)
                ttcc_pkg::OP_NOP:   state_next = ST_DONE;
                ttcc_pkg::OP_CR: begin
                    col_next   = '0;
                    state_next = ST_DONE;
                end
                ttcc_pkg::OP_BS:    state_next = ST_BS;
                ttcc_pkg::OP_NL: begin
                    nl_left_next = ttcc_pkg::NL_CNT_W'(1);
                    state_next   = ST_NL;
                end
                ttcc_pkg::OP_VT: begin
                    nl_left_next = ttcc_pkg::VT_LINES;
                    state_next   = ST_NL;
                end
                ttcc_pkg::OP_TAB:   state_next = ST_TAB;
                ttcc_pkg::OP_PRINT: state_next = ST_WRITE;
                default:            state_next = ST_DONE;
            endcase
        end
    end

    assign col_wide = 32'(emit_col);
    assign row_wide = 32'(row_reg);

    always_comb begin
        m_valid_next = m_valid_reg && !m_tready;
        m_kind_next  = m_kind_reg;
        m_col_next   = m_col_reg;
        m_row_next   = m_row_reg;
        m_glyph_next = m_glyph_reg;
        m_last_next  = m_last_reg;
        if (emit) begin
            m_valid_next = 1'b1;
            m_kind_next  = emit_kind;
            m_glyph_next = emit_glyph;
            m_last_next  = emit_kind == ttcc_pkg::KIND_DONE;
            if (emit_kind == ttcc_pkg::KIND_SCROLL) begin
                m_col_next = 7'd0;
                m_row_next = 6'd0;
            end else begin
                m_col_next = col_wide[6:0];
                m_row_next = row_wide[5:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        glyph_reg   <= glyph_next;
        m_kind_reg  <= m_kind_next;
        m_col_reg   <= m_col_next;
        m_row_reg   <= m_row_next;
        m_glyph_reg <= m_glyph_next;
        m_last_reg  <= m_last_next;
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            col_reg     <= '0;
            row_reg     <= '0;
            nl_left_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            nl_left_reg <= nl_left_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'd0, m_glyph_reg, m_row_reg, m_col_reg};
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;

    a_last_on_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_last_reg == (m_kind_reg == ttcc_pkg::KIND_DONE)))
        else $error("last flag does not match done kind");

    a_nl_count: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_NL |-> nl_left_reg != '0)
        else $error("newline stage entered with no lines left");

    a_scroll_row: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && emit_kind == ttcc_pkg::KIND_SCROLL) |=> row_reg == $past(row_top))
        else $error("scroll did not park cursor on bottom row");

    a_pop_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> (state_reg == ST_IDLE || (state_reg == ST_DONE && emit)))
        else $error("command taken while previous one still running");

endmodule

### design/text_terminal_cursor_controller_top.sv
// Top level of the text terminal cursor controller.
//
// Usage: one character code per item enters on the s_ stream (s_tdata[7:0]).
// For each item the m_ stream gives cell-write and scroll items in order and
// then one done item carrying the cursor position, marked by m_tlast.
// m_tuser holds the kind: 0 cell write, 1 scroll, 2 done.
// Registers on the APB port: enable at 0x0, columns at 0x4, rows at 0x8.
// Flow: with the engine idle, a command is taken from the queue into the engine
// state and its first result item is then registered in the output register.
// The engine steps once per result item plus once for each tab, each backspace
// at column 0 and each newline that does not scroll. A printable character that
// wraps adds a newline step, a vertical tab runs VT_LINES newline steps, and bell,
// form feed, carriage return or a disabled terminal give only the done item. The
// engine goes back to idle when the queue ran empty. A two-entry command queue
// lets input items be taken while the engine works or the receiver stalls; when
// the queue is full s_tready drops. When m_tready is low the output register
// holds its item and the engine waits to emit more. Reset clears the cursor to
// column 0, row 0, empties the queue and sets enable 0, columns 80, rows 25.
module text_terminal_cursor_controller_top #(
    parameter int MAX_COLUMNS = ttcc_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_ROWS    = ttcc_pkg::MAX_ROWS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ttcc_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [7:0] char_code
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [23:0]                     m_tdata,   // [6:0] col, [12:7] row, [20:13] glyph
    output logic [1:0]                      m_tuser,   // [1:0] kind
    output logic                            m_tlast
);

    logic                                 q_push;
    logic                                 q_in_ready;
    logic                                 q_valid;
    logic                                 q_pop;
    ttcc_pkg::cmd_t                       push_cmd;
    ttcc_pkg::cmd_t                       head_cmd;
    logic [$clog2(MAX_COLUMNS+1)-1:0]     width_eff;
    logic [$clog2(MAX_ROWS+1)-1:0]        height_eff;

    ttcc_front #(
        .MAX_COLUMNS(MAX_COLUMNS),
        .MAX_ROWS   (MAX_ROWS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .q_ready   (q_in_ready),
        .q_push    (q_push),
        .q_cmd     (push_cmd),
        .width_eff (width_eff),
        .height_eff(height_eff)
    );

    ttcc_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (push_cmd),
        .in_ready (q_in_ready),
        .pop      (q_pop),
        .out_valid(q_valid),
        .out_cmd  (head_cmd)
    );

    ttcc_back #(
        .MAX_COLUMNS(MAX_COLUMNS),
        .MAX_ROWS   (MAX_ROWS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_cmd     (head_cmd),
        .q_pop     (q_pop),
        .width_eff (width_eff),
        .height_eff(height_eff),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule
